@@ hw/rtl/aast_pkg.sv @@
// Shared types and constants for the aim angle slew tracker.
// Holds the CORDIC arctangent table and the controller/datapath command bundles.
// No dependencies.
package aast_pkg;

  // Binary angle width (32768 = pi).
  localparam int ANGLE_W    = 16;
  // Accumulated CORDIC angle width (2^32 = 2*pi).
  localparam int ZACC_W     = 32;
  // CORDIC vector component width: 16-bit input scaled by 2^16 plus gain headroom.
  localparam int XY_W       = 34;
  // Arctangent table length and the width of its index.
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  // Largest heading step, half a turn.
  localparam logic [ANGLE_W-1:0] STEP_MAX   = 16'h8000;
  // Half-unit bias for rounding the angle accumulator to 16 bits.
  localparam logic [ZACC_W-1:0]  ROUND_HALF = 32'h0000_8000;
  // Starting angle for a vector turned by pi.
  localparam logic [ZACC_W-1:0]  ANGLE_PI   = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;  // write zero at the clearing address
    logic load;      // capture an input transaction and start the table read
    logic iter;      // run one CORDIC micro-rotation
    logic tgt;       // round the target and saturate the step
    logic commit;    // write the new heading back and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clearing pass is at its final entry
    logic iter_last;   // current micro-rotation is the final one
  } status_t;

  // atan(2^-i) as a 32-bit binary angle.
  function automatic logic [ZACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [ZACC_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/aast_in_if.sv @@
// Input channel of the aim angle slew tracker: valid/ready plus the aim request.
// Depends on nothing.
interface aast_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        entity;
  logic signed [15:0] aim_x;
  logic signed [15:0] aim_y;
  logic [15:0]       delta_time;

  modport source (output valid, entity, aim_x, aim_y, delta_time, input ready);
  modport sink   (input valid, entity, aim_x, aim_y, delta_time, output ready);
endinterface

@@ hw/rtl/aast_out_if.sv @@
// Output channel of the aim angle slew tracker: valid/ready plus the heading result.
// Depends on nothing.
interface aast_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        entity_out;
  logic signed [15:0] new_heading;
  logic signed [15:0] target_heading;

  modport source (output valid, entity_out, new_heading, target_heading, input ready);
  modport sink   (input valid, entity_out, new_heading, target_heading, output ready);
endinterface

@@ hw/rtl/aast_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module aast_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/aast_ctrl.sv @@
// Controller for the aim angle slew tracker: sequences clearing, CORDIC and commit.
// Depends on aast_pkg for the command and status bundles.
module aast_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  aast_pkg::status_t status,
  output aast_pkg::cmd_t    cmd
);
  import aast_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ITER   = 3'd2;
  localparam logic [2:0] ST_TGT    = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (status.iter_last) begin
          state_next = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.tgt    = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // Wait until the result register is free or being emptied.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign in_ready       = (state == ST_IDLE);
  assign out_valid_next = cmd.commit | (out_valid & ~out_ready);

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/aast_dp.sv @@
// Datapath for the aim angle slew tracker: CORDIC atan2, slew step and heading table.
// Depends on aast_pkg and instantiates aast_ram.
module aast_dp #(
  parameter int ENTITY_COUNT = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  aast_pkg::cmd_t     cmd,
  output aast_pkg::status_t  status,
  input  logic               slew_rate_we,
  input  logic [15:0]        slew_rate_wdata,
  input  logic [7:0]         entity,
  input  logic signed [15:0] aim_x,
  input  logic signed [15:0] aim_y,
  input  logic [15:0]        delta_time,
  output logic [7:0]         entity_out,
  output logic signed [15:0] new_heading,
  output logic signed [15:0] target_heading
);
  import aast_pkg::*;

  localparam int IDX_W = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
  localparam int RED_W = 20;
  localparam logic [RED_W-1:0]      COUNT_R   = RED_W'(ENTITY_COUNT);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTITY_COUNT - 1);
  localparam logic [ATAN_IDX_W-1:0] LAST_ITER = ATAN_IDX_W'(CORDIC_STEPS - 1);

  logic [15:0]               slew_rate;
  logic [IDX_W-1:0]          clear_addr;
  logic [7:0]                ent_q;
  logic [IDX_W-1:0]          idx_q;
  logic [IDX_W-1:0]          idx_in;
  logic signed [XY_W-1:0]    x_q;
  logic signed [XY_W-1:0]    y_q;
  logic [ZACC_W-1:0]         z_q;
  logic [ATAN_IDX_W-1:0]     iter_q;
  logic                      zero_q;
  logic                      rate_zero_q;
  logic [31:0]               prod_q;
  logic [ANGLE_W-1:0]        target_q;
  logic [ANGLE_W-1:0]        step_q;
  logic signed [XY_W-1:0]    x_in;
  logic signed [XY_W-1:0]    y_in;
  logic signed [XY_W-1:0]    xs;
  logic signed [XY_W-1:0]    ys;
  logic [ZACC_W-1:0]         atan_val;
  logic [ZACC_W-1:0]         z_round;
  logic [ANGLE_W-1:0]        step_raw;
  logic [ANGLE_W-1:0]        cur;
  logic [ANGLE_W-1:0]        diff;
  logic [ANGLE_W-1:0]        mag;
  logic [ANGLE_W-1:0]        next_heading;
  logic [RED_W-1:0]          red;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [ANGLE_W-1:0]        ram_wdata;

  // Slew rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slew_rate <= '0;
    end else if (slew_rate_we) begin
      slew_rate <= slew_rate_wdata;
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign status.clear_last = (clear_addr == LAST_IDX);
  assign status.iter_last  = (iter_q == LAST_ITER);

  // Table index: entity modulo the entity count by restoring compare-subtract.
  always_comb begin
    red = RED_W'(entity);
    for (int k = 7; k >= 0; k--) begin
      if (red >= (COUNT_R << k)) begin
        red = red - (COUNT_R << k);
      end
    end
    idx_in = red[IDX_W-1:0];
  end

  // Vector scaled by 2^16; a vector with negative x is turned by pi.
  always_comb begin
    x_in = XY_W'({{2{aim_x[15]}}, aim_x, 16'h0000});
    y_in = XY_W'({{2{aim_y[15]}}, aim_y, 16'h0000});
    if (aim_x[15]) begin
      x_in = -x_in;
      y_in = -y_in;
    end
  end

  // One CORDIC micro-rotation per cycle.
  assign xs       = x_q >>> iter_q;
  assign ys       = y_q >>> iter_q;
  assign atan_val = atan_entry(iter_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ent_q       <= entity;
      idx_q       <= idx_in;
      x_q         <= x_in;
      y_q         <= y_in;
      z_q         <= aim_x[15] ? ANGLE_PI : '0;
      iter_q      <= '0;
      zero_q      <= (aim_x == 16'sd0) && (aim_y == 16'sd0);
      rate_zero_q <= (slew_rate == 16'd0);
      prod_q      <= slew_rate * delta_time;
    end else if (cmd.iter) begin
      if (!y_q[XY_W-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_val;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_val;
      end
      iter_q <= iter_q + 1'b1;
    end
  end

  // Round the target angle and saturate the step to half a turn.
  assign z_round  = z_q + ROUND_HALF;
  assign step_raw = prod_q[31:16];

  always_ff @(posedge clk) begin
    if (cmd.tgt) begin
      target_q <= zero_q ? '0 : z_round[ZACC_W-1:ZACC_W-ANGLE_W];
      step_q   <= (step_raw > STEP_MAX) ? STEP_MAX : step_raw;
    end
  end

  // Move along the shorter arc; a gap of half a turn goes the positive way.
  always_comb begin
    diff = target_q - cur;
    mag  = diff[ANGLE_W-1] ? (~diff + 1'b1) : diff;
    if (rate_zero_q || (mag < step_q)) begin
      next_heading = target_q;
    end else if (!diff[ANGLE_W-1] || (diff == STEP_MAX)) begin
      next_heading = cur + step_q;
    end else begin
      next_heading = cur - step_q;
    end
  end

  // Heading table port selection: clearing sweep or write-back.
  assign ram_we    = cmd.clear_wr | cmd.commit;
  assign ram_waddr = cmd.clear_wr ? clear_addr : idx_q;
  assign ram_wdata = cmd.clear_wr ? '0 : next_heading;

  aast_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (ENTITY_COUNT)
  ) u_heading_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (idx_in),
    .rdata (cur)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      entity_out     <= ent_q;
      new_heading    <= next_heading;
      target_heading <= target_q;
    end
  end

endmodule

@@ hw/rtl/aim_angle_slew_tracker.sv @@
// Top level of the aim angle slew tracker: joins the controller and the datapath.
// Depends on aast_pkg, aast_in_if, aast_out_if, aast_ctrl and aast_dp.
//
//   Channel     Dir  Handshake          Carries
//   in_ch       in   valid/ready        entity, aim_x, aim_y, delta_time
//   out_ch      out  valid/ready        entity_out, new_heading, target_heading
//   slew_rate   in   write enable only  slew_rate_wdata
//
// An accepted transaction runs CORDIC_STEPS micro-rotations, one per cycle, rounds
// the target, saturates the step and writes back the heading and result; the next
// is then taken. After reset every heading table entry is cleared before the first
// input transaction is accepted. The result register frees the input side: a new
// transaction is taken while a result waits, and only the write-back waits on out_ch.
module aim_angle_slew_tracker #(
  parameter int ENTITY_COUNT = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        slew_rate_we,
  input  logic [15:0] slew_rate_wdata,
  aast_in_if.sink     in_ch,
  aast_out_if.source  out_ch
);
  import aast_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  aast_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and heading storage.
  aast_dp #(
    .ENTITY_COUNT (ENTITY_COUNT),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .slew_rate_we    (slew_rate_we),
    .slew_rate_wdata (slew_rate_wdata),
    .entity          (in_ch.entity),
    .aim_x           (in_ch.aim_x),
    .aim_y           (in_ch.aim_y),
    .delta_time      (in_ch.delta_time),
    .entity_out      (out_ch.entity_out),
    .new_heading     (out_ch.new_heading),
    .target_heading  (out_ch.target_heading)
  );

endmodule

@@ hw/rtl/aast_checker.sv @@
// Port-level checks for the aim angle slew tracker, bound to the top level.
// Depends on aim_angle_slew_tracker and its channel interfaces.
module aast_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  entity_out,
  input logic [15:0] new_heading,
  input logic [15:0] target_heading
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entity_out) &&
      $stable(new_heading) && $stable(target_heading))
    else $error("result changed while stalled");

  // After reset no result is pending and the clearing pass blocks input.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("reset left result valid or input open");

  // An accepted transaction closes the input.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // A new result only appears after the input was closed.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work");

endmodule

bind aim_angle_slew_tracker aast_checker u_aast_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .entity_out     (out_ch.entity_out),
  .new_heading    (out_ch.new_heading),
  .target_heading (out_ch.target_heading)
);
